/* rtl/bfha_pkg.sv */
package bfha_pkg;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_ZERO_SIZE  = 3'd1;
   localparam logic [2:0] ST_NO_FIT     = 3'd2;
   localparam logic [2:0] ST_NOT_BLOCK  = 3'd3;
   localparam logic [2:0] ST_ALRDY_FREE = 3'd4;
   localparam logic [2:0] ST_NULL       = 3'd5;

   localparam int SIZE_W  = 34;
   localparam int OFF_W   = 21;
   localparam int ALIGN   = 16;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_A_RD,
      S_A_EV,
      S_A_FIN,
      S_A_BEST,
      S_F_RD,
      S_F_EV,
      S_R_CHK,
      S_R_EV,
      S_L_CHK,
      S_L_EV,
      S_UPD_RD,
      S_UPD_WR,
      S_RESP
   } seq_state_type;

endpackage

/* rtl/bfha_ram.sv */
module bfha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* rtl/best_fit_heap_allocator_top.sv */
// Channel   Handshake            Payload
// request   start / busy         req_opcode, req_alloc_size, req_free_offset
// response  rsp_valid (strobe)   rsp_status, rsp_payload_offset, rsp_merge_count
//
// One transaction at a time; busy stays high from acceptance until the response strobe.
// Allocate: walks the block list for the best fit, then finishes; a split also relinks its successor.
// Free: scans table entries through the match, then merges neighbors, relinking after each merge.
// After reset the block writes the initial arena record before it goes idle.
// The receiver cannot stall: the response strobe lasts exactly one cycle.
module best_fit_heap_allocator_top
   import bfha_pkg::*;
#(
   parameter int ARENA_BYTES  = 1048576,
   parameter int HEADER_BYTES = 32,
   parameter int MAX_BLOCKS   = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [31:0] req_alloc_size,
   input  logic [20:0] req_free_offset,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [20:0] rsp_payload_offset,
   output logic [1:0]  rsp_merge_count
);

   // byte offsets and sizes, index with room for the "none" marker, RAM address
   localparam int AW  = $clog2(ARENA_BYTES) + 1;
   localparam int IW  = $clog2(MAX_BLOCKS + 1);
   localparam int AIW = $clog2(MAX_BLOCKS);
   localparam int RW  = 2 * AW + 1 + 2 * IW;
   localparam logic [IW-1:0] NONE = IW'(MAX_BLOCKS);
   localparam logic [SIZE_W-1:0] HDR = SIZE_W'(HEADER_BYTES);

   seq_state_type state_ff, state_in, ret_ff, ret_in;

   logic              op_ff, op_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic [IW-1:0]     cur_ff, cur_in;
   logic [IW-1:0]     guard_ff, guard_in;
   logic [IW-1:0]     best_ff, best_in;
   logic [1:0]        count_ff, count_in;
   logic [IW-1:0]     upd_idx_ff, upd_idx_in;
   logic [IW-1:0]     upd_val_ff, upd_val_in;
   logic [MAX_BLOCKS-1:0] valid_ff, valid_in;

   // working record: best candidate on allocate, current block on free
   logic [AW-1:0] cs_ff, cs_in, cz_ff, cz_in;
   logic          cu_ff, cu_in;
   logic [IW-1:0] cn_ff, cn_in, cp_ff, cp_in;

   logic [2:0]       st_ff, st_in;
   logic [OFF_W-1:0] pay_ff, pay_in;

   // block RAM ports
   logic           wr_en, rd_en;
   logic [AIW-1:0] wr_addr, rd_addr;
   logic [RW-1:0]  wr_data, rd_data;
   logic [AW-1:0]  rd_start, rd_size;
   logic           rd_used;
   logic [IW-1:0]  rd_next, rd_prev;

   assign {rd_start, rd_size, rd_used, rd_next, rd_prev} = rd_data;

   bfha_ram #(.WIDTH(RW), .DEPTH(MAX_BLOCKS)) u_blocks (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // lowest unused table entry for a split
   logic [IW-1:0] slot;
   logic          slot_ok;
   always_comb begin
      slot    = NONE;
      slot_ok = 1'b0;
      for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            slot    = IW'(i);
            slot_ok = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         valid_ff <= MAX_BLOCKS'(1);
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      ret_ff     <= ret_in;
      op_ff      <= op_in;
      size_ff    <= size_in;
      off_ff     <= off_in;
      cur_ff     <= cur_in;
      guard_ff   <= guard_in;
      best_ff    <= best_in;
      count_ff   <= count_in;
      upd_idx_ff <= upd_idx_in;
      upd_val_ff <= upd_val_in;
      cs_ff      <= cs_in;
      cz_ff      <= cz_in;
      cu_ff      <= cu_in;
      cn_ff      <= cn_in;
      cp_ff      <= cp_in;
      st_ff      <= st_in;
      pay_ff     <= pay_in;
   end

   logic [SIZE_W-1:0] rd_size_x;
   logic [SIZE_W-1:0] cz_x;
   assign rd_size_x = SIZE_W'(rd_size);
   assign cz_x      = SIZE_W'(cz_ff);

   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      op_in      = op_ff;
      size_in    = size_ff;
      off_in     = off_ff;
      cur_in     = cur_ff;
      guard_in   = guard_ff;
      best_in    = best_ff;
      count_in   = count_ff;
      upd_idx_in = upd_idx_ff;
      upd_val_in = upd_val_ff;
      valid_in   = valid_ff;
      cs_in      = cs_ff;
      cz_in      = cz_ff;
      cu_in      = cu_ff;
      cn_in      = cn_ff;
      cp_in      = cp_ff;
      st_in      = st_ff;
      pay_in     = pay_ff;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = '0;
      rd_en      = 1'b0;
      rd_addr    = '0;

      unique case (state_ff)
         S_INIT: begin
            // write the one free block that spans the arena
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = {AW'(0), AW'(ARENA_BYTES - HEADER_BYTES), 1'b0, NONE, NONE};
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               op_in    = req_opcode;
               off_in   = req_free_offset;
               size_in  = (SIZE_W'(req_alloc_size) + SIZE_W'(ALIGN - 1))
                          & ~SIZE_W'(ALIGN - 1);
               cur_in   = '0;
               guard_in = '0;
               best_in  = NONE;
               count_in = '0;
               st_in    = ST_OK;
               pay_in   = '0;
               if (req_opcode == OP_ALLOC) begin
                  if (req_alloc_size == '0) begin
                     st_in    = ST_ZERO_SIZE;
                     state_in = S_RESP;
                  end else begin
                     state_in = S_A_RD;
                  end
               end else if (req_free_offset == '0) begin
                  st_in    = ST_NULL;
                  state_in = S_RESP;
               end else begin
                  state_in = S_F_RD;
               end
            end
         end
         S_A_RD: begin
            // follow the address-ordered list
            if (cur_ff < NONE && valid_ff[cur_ff[AIW-1:0]] && guard_ff < NONE) begin
               rd_en    = 1'b1;
               rd_addr  = cur_ff[AIW-1:0];
               state_in = S_A_EV;
            end else begin
               state_in = S_A_FIN;
            end
         end
         S_A_EV: begin
            state_in = S_A_RD;
            cur_in   = rd_next;
            guard_in = guard_ff + 1'b1;
            if (!rd_used && rd_size_x >= size_ff && (best_ff == NONE || rd_size < cz_ff)) begin
               best_in = cur_ff;
               cs_in   = rd_start;
               cz_in   = rd_size;
               cu_in   = rd_used;
               cn_in   = rd_next;
               cp_in   = rd_prev;
               if (rd_size_x == size_ff) begin
                  state_in = S_A_FIN;
               end
            end
         end
         S_A_FIN: begin
            if (best_ff == NONE) begin
               st_in    = ST_NO_FIT;
               state_in = S_RESP;
            end else begin
               state_in = S_A_BEST;
               if (cz_x >= size_ff + HDR + SIZE_W'(ALIGN) && slot_ok) begin
                  // split the tail off as a new free block
                  wr_en   = 1'b1;
                  wr_addr = slot[AIW-1:0];
                  wr_data = {AW'(SIZE_W'(cs_ff) + HDR + size_ff),
                             AW'(cz_x - size_ff - HDR), 1'b0, cn_ff, best_ff};
                  valid_in[slot[AIW-1:0]] = 1'b1;
                  cz_in = AW'(size_ff);
                  cn_in = slot;
                  if (cn_ff < NONE) begin
                     upd_idx_in = cn_ff;
                     upd_val_in = slot;
                     ret_in     = S_A_BEST;
                     state_in   = S_UPD_RD;
                  end
               end
            end
         end
         S_A_BEST: begin
            wr_en    = 1'b1;
            wr_addr  = best_ff[AIW-1:0];
            wr_data  = {cs_ff, cz_ff, 1'b1, cn_ff, cp_ff};
            st_in    = ST_OK;
            pay_in   = OFF_W'(SIZE_W'(cs_ff) + HDR);
            state_in = S_RESP;
         end
         S_F_RD: begin
            rd_en    = 1'b1;
            rd_addr  = cur_ff[AIW-1:0];
            state_in = S_F_EV;
         end
         S_F_EV: begin
            if (valid_ff[cur_ff[AIW-1:0]] && SIZE_W'(rd_start) + HDR == SIZE_W'(off_ff)) begin
               if (!rd_used) begin
                  st_in    = ST_ALRDY_FREE;
                  state_in = S_RESP;
               end else begin
                  cs_in    = rd_start;
                  cz_in    = rd_size;
                  cu_in    = 1'b0;
                  cn_in    = rd_next;
                  cp_in    = rd_prev;
                  state_in = S_R_CHK;
               end
            end else if (cur_ff == NONE - 1'b1) begin
               st_in    = ST_NOT_BLOCK;
               state_in = S_RESP;
            end else begin
               cur_in   = cur_ff + 1'b1;
               state_in = S_F_RD;
            end
         end
         S_R_CHK: begin
            if (cn_ff < NONE && count_ff < 2'd3) begin
               rd_en    = 1'b1;
               rd_addr  = cn_ff[AIW-1:0];
               state_in = S_R_EV;
            end else begin
               state_in = S_L_CHK;
            end
         end
         S_R_EV: begin
            if (!rd_used) begin
               // absorb the right neighbor
               cz_in    = AW'(cz_x + HDR + rd_size_x);
               cn_in    = rd_next;
               valid_in[cn_ff[AIW-1:0]] = 1'b0;
               count_in = count_ff + 1'b1;
               state_in = S_R_CHK;
               if (rd_next < NONE) begin
                  upd_idx_in = rd_next;
                  upd_val_in = cur_ff;
                  ret_in     = S_R_CHK;
                  state_in   = S_UPD_RD;
               end
            end else begin
               state_in = S_L_CHK;
            end
         end
         S_L_CHK: begin
            wr_en   = 1'b1;
            wr_addr = cur_ff[AIW-1:0];
            wr_data = {cs_ff, cz_ff, cu_ff, cn_ff, cp_ff};
            if (cp_ff < NONE && count_ff < 2'd3) begin
               rd_en    = 1'b1;
               rd_addr  = cp_ff[AIW-1:0];
               state_in = S_L_EV;
            end else begin
               st_in    = ST_OK;
               state_in = S_RESP;
            end
         end
         S_L_EV: begin
            if (!rd_used) begin
               // fold the current block into its left neighbor
               cs_in    = rd_start;
               cz_in    = AW'(rd_size_x + HDR + cz_x);
               cu_in    = rd_used;
               cp_in    = rd_prev;
               valid_in[cur_ff[AIW-1:0]] = 1'b0;
               cur_in   = cp_ff;
               count_in = count_ff + 1'b1;
               state_in = S_L_CHK;
               if (cn_ff < NONE) begin
                  upd_idx_in = cn_ff;
                  upd_val_in = cp_ff;
                  ret_in     = S_L_CHK;
                  state_in   = S_UPD_RD;
               end
            end else begin
               st_in    = ST_OK;
               state_in = S_RESP;
            end
         end
         S_UPD_RD: begin
            rd_en    = 1'b1;
            rd_addr  = upd_idx_ff[AIW-1:0];
            state_in = S_UPD_WR;
         end
         S_UPD_WR: begin
            // relink the prev pointer of the following block
            wr_en    = 1'b1;
            wr_addr  = upd_idx_ff[AIW-1:0];
            wr_data  = {rd_start, rd_size, rd_used, rd_next, upd_val_ff};
            state_in = ret_ff;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = (state_ff == S_RESP);
   assign rsp_status         = st_ff;
   assign rsp_payload_offset = pay_ff;
   assign rsp_merge_count    = (op_ff == OP_FREE && st_ff == ST_OK) ? count_ff : 2'd0;

endmodule

/* rtl/bfha_checker.sv */
module bfha_checker
   import bfha_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [2:0]  rsp_status,
   input logic [20:0] rsp_payload_offset,
   input logic [1:0]  rsp_merge_count
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted transaction did not raise busy");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("response while idle");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy) else $error("response strobe too long");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_payload_offset == '0 && rsp_merge_count == '0)
      else $error("failed transaction carries data");

   a_merge_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_merge_count != '0 |-> rsp_payload_offset == '0)
      else $error("merge count on allocate");

endmodule

bind best_fit_heap_allocator_top bfha_checker u_bfha_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_status         (rsp_status),
   .rsp_payload_offset (rsp_payload_offset),
   .rsp_merge_count    (rsp_merge_count)
);
